### design/cfm_pkg.sv
package cfm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 8;
    localparam int PHASE_W  = 8;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    typedef enum logic [1:0] {
        MODE_SLOW   = 2'd0,
        MODE_FAST   = 2'd1,
        MODE_IDLE_A = 2'd2,
        MODE_IDLE_B = 2'd3
    } t_baud_mode;

    typedef enum logic [0:0] {
        REG_BAUD_MODE = 1'b0,
        REG_THRESHOLD = 1'b1
    } t_reg_index;

    localparam t_baud_mode             RST_BAUD_MODE = MODE_IDLE_B;
    localparam logic signed [SAMPLE_W-1:0] RST_THRESHOLD = 16'sd655;

    localparam logic [LEN_W-1:0] LEN_MAX     = 8'hff;
    localparam logic [LEN_W-1:0] SLOW_SHORT  = 8'h06;
    localparam logic [LEN_W-1:0] FAST_SHORT  = 8'd10;
    localparam logic [LEN_W-1:0] LONG_LIMIT  = 8'h20;

    typedef struct packed {
        logic active;
        logic fast;
    } t_step_ctrl;

endpackage

### design/cfm_in_if.sv
interface cfm_in_if;
    import cfm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] tape_sample;
    logic                       uart_serial_out;

    modport source (output valid, output tape_sample, output uart_serial_out, input ready);
    modport sink   (input valid, input tape_sample, input uart_serial_out, output ready);
endinterface

### design/cfm_out_if.sv
interface cfm_out_if;
    logic valid;
    logic ready;
    logic uart_serial_in;
    logic serial_in_update;
    logic tape_out_level;
    logic tape_out_update;

    modport source (output valid, output uart_serial_in, output serial_in_update,
                    output tape_out_level, output tape_out_update, input ready);
    modport sink   (input valid, input uart_serial_in, input serial_in_update,
                    input tape_out_level, input tape_out_update, output ready);
endinterface

### design/cassette_fsk_modem.sv
// Cassette FSK modem ticked at 19200 Hz, one input transfer per tick and one result
// transfer per input. Mode 0 runs at 300 baud, mode 1 at 1200 baud; modes 2 and 3
// leave all state untouched and report both update flags as 0. The decoder turns the
// length of each half-cycle of the thresholded tape input into the UART receive bit;
// the encoder resamples the UART transmit bit on bit boundaries and drives the tape
// level. For each tick the decoder and encoder update their counters in
// the accepting cycle and the result register presents the outcome the next cycle,
// so a new tick is taken every clock while the result is taken as fast. Registers
// are written over APB at 0x0 (baud mode, reset 3) and 0x4 (level threshold, reset
// 655); write them only while no tick is in flight.
module cassette_fsk_modem
    import cfm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    cfm_in_if.sink            i_item,
    cfm_out_if.source         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_baud_mode                 r_mode;
    logic signed [SAMPLE_W-1:0] r_threshold;
    logic                       r_valid;
    logic                       r_serial_in;
    logic                       r_serial_upd;
    logic                       r_tape_level;
    logic                       r_tape_upd;

    t_step_ctrl ctrl;
    t_reg_index reg_idx;
    logic       step;
    logic       cfg_write;
    logic       dec_bit;
    logic       dec_upd;
    logic       enc_level;
    logic       enc_upd;

    assign reg_idx    = t_reg_index'(paddr[2]);
    assign cfg_write  = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign ctrl.active = (r_mode == MODE_SLOW) || (r_mode == MODE_FAST);
    assign ctrl.fast   = (r_mode == MODE_FAST);

    assign i_item.ready = !r_valid || o_result.ready;
    assign step         = i_item.valid && i_item.ready;

    always_comb begin
        unique case (reg_idx)
            REG_BAUD_MODE: prdata = {{(APB_DW-2){1'b0}}, r_mode};
            REG_THRESHOLD: prdata = APB_DW'(r_threshold);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= RST_BAUD_MODE;
            r_threshold <= RST_THRESHOLD;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_BAUD_MODE: r_mode      <= t_baud_mode'(pwdata[1:0]);
                REG_THRESHOLD: r_threshold <= pwdata[SAMPLE_W-1:0];
                default:       r_mode      <= r_mode;
            endcase
        end
    end

    cfm_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_ctrl      (ctrl),
        .i_sample    (i_item.tape_sample),
        .i_threshold (r_threshold),
        .o_bit       (dec_bit),
        .o_update    (dec_upd)
    );

    cfm_encoder u_encoder (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_ctrl     (ctrl),
        .i_uart_bit (i_item.uart_serial_out),
        .o_level    (enc_level),
        .o_update   (enc_upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_serial_in  <= dec_bit;
            r_serial_upd <= dec_upd;
            r_tape_level <= enc_level;
            r_tape_upd   <= enc_upd;
        end
    end

    assign o_result.valid            = r_valid;
    assign o_result.uart_serial_in   = r_serial_in;
    assign o_result.serial_in_update = r_serial_upd;
    assign o_result.tape_out_level   = r_tape_level;
    assign o_result.tape_out_update  = r_tape_upd;

endmodule

### design/cfm_decoder.sv
module cfm_decoder
    import cfm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  t_step_ctrl                 i_ctrl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [SAMPLE_W-1:0] i_threshold,
    output logic                       o_bit,
    output logic                       o_update
);

    logic [LEN_W-1:0] r_len, n_len;
    logic             r_last, n_last;
    logic             r_bit, n_bit;
    logic [LEN_W-1:0] len_inc;
    logic             level;
    logic             change;
    logic             fire;

    always_comb begin
        len_inc = (r_len == LEN_MAX) ? r_len : r_len + LEN_W'(1);
        level   = (i_sample > i_threshold);
        change  = (level != r_last);
        fire    = change || (i_ctrl.fast && (len_inc == FAST_SHORT));
        n_len   = r_len;
        n_last  = r_last;
        n_bit   = r_bit;
        o_update = 1'b0;
        if (i_ctrl.active) begin
            n_len = change ? '0 : len_inc;
            n_last = level;
            if (fire) begin
                n_bit = (len_inc < (i_ctrl.fast ? FAST_SHORT : SLOW_SHORT))
                        || (len_inc > LONG_LIMIT);
                o_update = 1'b1;
            end
        end
        o_bit = n_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_last <= 1'b0;
            r_bit  <= 1'b1;
        end else if (i_step) begin
            r_len  <= n_len;
            r_last <= n_last;
            r_bit  <= n_bit;
        end
    end

endmodule

### design/cfm_encoder.sv
module cfm_encoder
    import cfm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_step_ctrl i_ctrl,
    input  logic       i_uart_bit,
    output logic       o_level,
    output logic       o_update
);

    logic [PHASE_W-1:0] r_count, n_count;
    logic               r_held, n_held;
    logic               r_level, n_level;
    logic [PHASE_W-1:0] count_inc;
    logic               period_edge;
    logic               take;
    logic               toggle_edge;
    logic               skip;

    always_comb begin
        count_inc   = r_count + PHASE_W'(1);
        period_edge = i_ctrl.fast ? (count_inc[2:0] == 3'd0) : (count_inc[4:0] == 5'd0);
        take        = period_edge && (i_uart_bit != r_held);
        n_count     = take ? '0 : count_inc;
        n_held      = take ? i_uart_bit : r_held;
        toggle_edge = i_ctrl.fast ? (n_count[2:0] == 3'd0) : (n_count[1:0] == 2'd0);
        skip        = !n_held && (i_ctrl.fast ? n_count[3] : n_count[2]);
        o_update    = i_ctrl.active && toggle_edge && !skip;
        n_level     = r_level ^ o_update;
        if (!i_ctrl.active) begin
            n_count = r_count;
            n_held  = r_held;
        end
        o_level = n_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_held  <= 1'b0;
            r_level <= 1'b1;
        end else if (i_step) begin
            r_count <= n_count;
            r_held  <= n_held;
            r_level <= n_level;
        end
    end

endmodule

### design/cfm_checker.sv
module cfm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    logic in_xfer;

    assign in_xfer = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_in_gives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> i_out_valid)
        else $error("input transfer without result");

    a_out_from_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_xfer))
        else $error("result without input transfer");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind cassette_fsk_modem cfm_checker u_cfm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready)
);

### test/cassette_fsk_modem_test.sv
import cfm_pkg::*;

typedef struct packed {
    logic uart_serial_in;
    logic serial_in_update;
    logic tape_out_level;
    logic tape_out_update;
} tick_result_t;

class modem_tick_predictor;
    t_baud_mode                 baud_mode;
    logic signed [SAMPLE_W-1:0] level_threshold;
    logic [LEN_W-1:0]           half_length;
    logic                       last_level;
    logic                       decoded_bit;
    logic [PHASE_W-1:0]         phase_count;
    logic                       held_bit;
    logic                       wave_level;
    tick_result_t               expected_ticks[$];
    int                         failures;

    function new();
        baud_mode       = RST_BAUD_MODE;
        level_threshold = RST_THRESHOLD;
        half_length     = '0;
        last_level      = 1'b0;
        decoded_bit     = 1'b1;
        phase_count     = '0;
        held_bit        = 1'b0;
        wave_level      = 1'b1;
        failures        = 0;
    endfunction

    function void write_reg(t_reg_index idx, logic [APB_DW-1:0] value);
        case (idx)
            REG_BAUD_MODE: baud_mode = t_baud_mode'(value[1:0]);
            REG_THRESHOLD: level_threshold = value[SAMPLE_W-1:0];
            default: ;
        endcase
    endfunction

    function void take_tick(logic signed [SAMPLE_W-1:0] sample, logic uart_bit);
        tick_result_t       res;
        logic               fast;
        logic               level;
        logic               change;
        logic [PHASE_W-1:0] period_mask;
        logic [PHASE_W-1:0] toggle_mask;
        logic [PHASE_W-1:0] half_bit;
        res = '0;
        if (baud_mode == MODE_SLOW || baud_mode == MODE_FAST) begin
            fast        = (baud_mode == MODE_FAST);
            level       = (sample > level_threshold);
            change      = (level != last_level);
            period_mask = fast ? 8'h07 : 8'h1f;
            toggle_mask = fast ? 8'h07 : 8'h03;
            half_bit    = fast ? 8'h08 : 8'h04;
            if (half_length != LEN_MAX) half_length = half_length + 1'b1;
            if (!fast) begin
                if (change) begin
                    last_level  = level;
                    decoded_bit = (half_length < SLOW_SHORT || half_length > LONG_LIMIT);
                    half_length = '0;
                    res.serial_in_update = 1'b1;
                end
            end else if (change || half_length == FAST_SHORT) begin
                decoded_bit = (half_length < FAST_SHORT || half_length > LONG_LIMIT);
                if (change) begin
                    half_length = '0;
                    last_level  = level;
                end
                res.serial_in_update = 1'b1;
            end
            phase_count = phase_count + 1'b1;
            if ((phase_count & period_mask) == 0 && uart_bit != held_bit) begin
                held_bit    = uart_bit;
                phase_count = '0;
            end
            if ((phase_count & toggle_mask) == 0
                    && !(held_bit == 1'b0 && (phase_count & half_bit) != 0)) begin
                wave_level = ~wave_level;
                res.tape_out_update = 1'b1;
            end
        end
        res.uart_serial_in = decoded_bit;
        res.tape_out_level = wave_level;
        expected_ticks.push_back(res);
    endfunction

    function void check_result(logic si, logic si_upd, logic lvl, logic lvl_upd);
        tick_result_t want;
        if (expected_ticks.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("unexpected result transfer: si=%b si_upd=%b lvl=%b lvl_upd=%b",
                         si, si_upd, lvl, lvl_upd);
            return;
        end
        want = expected_ticks.pop_front();
        if (si !== want.uart_serial_in || si_upd !== want.serial_in_update
                || lvl !== want.tape_out_level || lvl_upd !== want.tape_out_update) begin
            failures++;
            if (failures <= 10)
                $display({"tick result mismatch: want si=%b si_upd=%b lvl=%b lvl_upd=%b,",
                          " got si=%b si_upd=%b lvl=%b lvl_upd=%b"},
                         want.uart_serial_in, want.serial_in_update,
                         want.tape_out_level, want.tape_out_update,
                         si, si_upd, lvl, lvl_upd);
        end
    endfunction

    function int pending();
        return expected_ticks.size();
    endfunction
endclass

module cassette_fsk_modem_test;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    cfm_in_if  in_ch ();
    cfm_out_if out_ch ();

    cassette_fsk_modem i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch),
        .o_result (out_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    modem_tick_predictor tick_model;

    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_cycles;
    int   cur_threshold;
    logic tone_level;
    int   tone_left;
    logic uart_bit;
    int   uart_left;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            tick_model.check_result(out_ch.uart_serial_in, out_ch.serial_in_update,
                                    out_ch.tape_out_level, out_ch.tape_out_update);
    end

    task automatic send_tick(logic signed [SAMPLE_W-1:0] sample, logic uart);
        in_ch.valid           <= 1'b1;
        in_ch.tape_sample     <= sample;
        in_ch.uart_serial_out <= uart;
        do @(posedge i_clk); while (!in_ch.ready);
        tick_model.take_tick(sample, uart);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic write_reg(t_reg_index idx, logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tick_model.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(t_baud_mode mode, int threshold);
        in_ch.valid <= 1'b0;
        while (tick_model.pending() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        write_reg(REG_BAUD_MODE, 32'(mode));
        write_reg(REG_THRESHOLD, 32'(threshold));
        cur_threshold = threshold;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] level_sample(logic high);
        int lo_v;
        int hi_v;
        if (high && cur_threshold < 32767) begin
            lo_v = cur_threshold + 1;
            hi_v = 32767;
        end else begin
            lo_v = -32768;
            hi_v = cur_threshold;
        end
        if ($urandom_range(3) == 0)
            return SAMPLE_W'(high ? lo_v : hi_v);
        return SAMPLE_W'(lo_v + int'($urandom_range(hi_v - lo_v)));
    endfunction

    function automatic int pick_half_length();
        case ($urandom_range(6))
            0:       return $urandom_range(5, 1);
            1:       return $urandom_range(7, 5);
            2:       return $urandom_range(11, 9);
            3:       return $urandom_range(31, 12);
            4:       return $urandom_range(34, 32);
            5:       return $urandom_range(60, 35);
            default: return $urandom_range(1) ? 4 : 8;
        endcase
    endfunction

    function automatic int pick_uart_run();
        case ($urandom_range(5))
            0:       return $urandom_range(7, 1);
            1:       return 8;
            2:       return 16;
            3:       return 32;
            4:       return 64;
            default: return $urandom_range(40, 9);
        endcase
    endfunction

    task automatic run_random(int count, bit saturate);
        logic signed [SAMPLE_W-1:0] sample;
        if (saturate) begin
            tone_level = ~tone_level;
            tone_left  = 300;
        end
        repeat (count) begin
            if (tone_left == 0) begin
                tone_level = ~tone_level;
                tone_left  = pick_half_length();
            end
            tone_left--;
            if (uart_left == 0) begin
                if ($urandom_range(3) != 0) uart_bit = ~uart_bit;
                uart_left = pick_uart_run();
            end
            uart_left--;
            if (!saturate && $urandom_range(9) == 0)
                sample = SAMPLE_W'($urandom);
            else
                sample = level_sample(tone_level);
            send_tick(sample, uart_bit);
        end
    endtask

    initial begin
        tick_model            = new();
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        in_ch.valid           = 1'b0;
        in_ch.tape_sample     = '0;
        in_ch.uart_serial_out = 1'b0;
        out_ch.ready          = 1'b0;
        hold_cycles           = 0;
        cur_threshold         = 655;
        tone_level            = 1'b0;
        tone_left             = 0;
        uart_bit              = 1'b0;
        uart_left             = 0;
        send_idle_pct         = 26;
        recv_idle_pct         = 73;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // inactive after reset
        send_tick(16'sh7fff, 1'b1);
        send_tick(-16'sd32768, 1'b0);
        send_tick(16'sd655, 1'b1);

        configure(MODE_SLOW, 655);
        send_tick(16'sd656, 1'b1);
        send_tick(16'sd655, 1'b1);
        send_tick(-16'sd32768, 1'b0);
        send_tick(16'sh7fff, 1'b0);
        send_tick(16'sh7fff, 1'b1);
        send_tick(16'sd0, 1'b1);

        // nothing reads high: force a bit out at length ten
        configure(MODE_FAST, 32767);
        repeat (11) send_tick(16'sh7fff, 1'b1);

        configure(MODE_FAST, -32768);
        send_tick(-16'sd32768, 1'b0);
        send_tick(-16'sd32767, 1'b0);
        send_tick(-16'sd32768, 1'b1);

        configure(MODE_SLOW, 655);
        run_random(30, 1'b0);
        configure(MODE_FAST, -1000);
        run_random(30, 1'b0);

        send_idle_pct = 73;
        recv_idle_pct = 26;
        configure(MODE_FAST, 32767);
        run_random(25, 1'b0);
        configure(MODE_SLOW, -32768);
        run_random(35, 1'b0);
        configure(MODE_IDLE_A, 0);
        run_random(15, 1'b0);
        configure(MODE_FAST, int'($urandom_range(65535)) - 32768);
        run_random(40, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // hold one level long enough to pin the half-cycle length at its limit
        configure(MODE_SLOW, int'($urandom_range(4000)) - 2000);
        run_random(280, 1'b1);
        configure(MODE_IDLE_B, int'($urandom_range(65535)) - 32768);
        run_random(15, 1'b0);
        configure(MODE_FAST, 0);
        // hold off results while ticks keep coming
        hold_cycles = 80;
        run_random(50, 1'b0);

        in_ch.valid <= 1'b0;
        while (tick_model.pending() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (tick_model.failures == 0 && tick_model.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
design/cfm_pkg.sv
design/cfm_in_if.sv
design/cfm_out_if.sv
design/cfm_decoder.sv
design/cfm_encoder.sv
design/cassette_fsk_modem.sv
design/cfm_checker.sv
test/cassette_fsk_modem_test.sv
